// ===== design/mark_sweep_block_collector_defines.svh =====
// Assertion shorthands shared by the checker.
`ifndef MARK_SWEEP_BLOCK_COLLECTOR_DEFINES_SVH
`define MARK_SWEEP_BLOCK_COLLECTOR_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define MSBC_IMPLY(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define MSBC_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== design/msbc_pkg.sv =====
package msbc_pkg;

  localparam int HEAP_BLOCKS = 16;
  localparam int ROOT_SLOTS  = 8;
  localparam int HEAP_IDX_W  = (HEAP_BLOCKS > 1) ? $clog2(HEAP_BLOCKS) : 1;
  localparam int DEPTH_W     = $clog2(ROOT_SLOTS + 1);
  localparam int CNT_W       = 5;

  typedef enum logic [1:0] {
    KIND_ALLOC   = 2'd0,
    KIND_PUSH    = 2'd1,
    KIND_POP     = 2'd2,
    KIND_COLLECT = 2'd3
  } msbc_kind_t;

  typedef enum logic [2:0] {
    STAT_OK        = 3'd0,
    STAT_HEAP_FULL = 3'd1,
    STAT_OVERFLOW  = 3'd2,
    STAT_INVALID   = 3'd3,
    STAT_UNDERFLOW = 3'd4
  } msbc_status_t;

  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_SWEEP = 3'b010,
    ST_DONE  = 3'b100
  } msbc_state_t;

  // Token walking down the heap cell chain.
  typedef struct packed {
    logic             vld;
    logic             collect;
    logic [CNT_W-1:0] rem;
  } msbc_tok_t;

endpackage

// ===== design/mark_sweep_block_collector.sv =====
// Push and pop: result word valid in the cycle after acceptance; next word taken right after unless the output stalls.
// Allocate and collect: a token walks the heap cell chain, one cell per cycle,
//   and the result is registered from the done state once the output is free;
//   one such item is in flight at a time.
// Reset (rst_n low, synchronous) empties the heap bitmap and the root stack and
//   drops any pending result; root entries themselves are not cleared.
module mark_sweep_block_collector (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_kind,
  input  logic [4:0]  in_block_count,
  input  logic [7:0]  in_root_index,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  out_status,
  output logic [15:0] out_changed_mask,
  output logic [3:0]  out_popped_index,
  output logic [15:0] out_live_mask,
  output logic [3:0]  out_roots_held
);

  localparam int HB = msbc_pkg::HEAP_BLOCKS;
  localparam int RS = msbc_pkg::ROOT_SLOTS;
  localparam int IW = msbc_pkg::HEAP_IDX_W;
  localparam int DW = msbc_pkg::DEPTH_W;

  // Control state
  msbc_pkg::msbc_state_t  state_r, state_nxt;
  logic [DW-1:0]          depth_r, depth_nxt;
  msbc_pkg::msbc_tok_t    launch_r, launch_nxt;
  msbc_pkg::msbc_status_t done_st_r, done_st_nxt;
  logic [HB-1:0]          marks_r, marks_nxt;

  // Output word register
  logic        out_valid_r, out_valid_nxt;
  logic [2:0]  out_status_r;
  logic [15:0] out_changed_r;
  logic [3:0]  out_popped_r;
  logic [15:0] out_live_r;
  logic [3:0]  out_held_r;

  // Values to load into the output word
  logic                   ld_out;
  msbc_pkg::msbc_status_t o_status;
  logic [HB-1:0]          o_changed;
  logic [IW-1:0]          o_popped;

  logic in_acc, out_free, push, pop, idx_ok;

  // Heap chain: tok[h] feeds cell h, tok[HB] is the tail
  msbc_pkg::msbc_tok_t tok [HB+1];
  logic [HB-1:0]       live;
  logic [HB-1:0]       chg;
  logic [HB-1:0]       mark_cmb;

  // Root chain: entry 0 is the top of stack
  logic [IW-1:0] root_val  [RS];
  logic [IW-1:0] root_up   [RS];
  logic [IW-1:0] root_down [RS];

  assign tok[0] = launch_r;

  for (genvar h = 0; h < HB; h++) begin : g_heap
    msbc_heap_cell u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .clr     (in_acc),
      .mark    (marks_r[h]),
      .tok_in  (tok[h]),
      .tok_out (tok[h+1]),
      .alloc   (live[h]),
      .changed (chg[h])
    );
  end

  for (genvar k = 0; k < RS; k++) begin : g_root
    if (k == 0) begin : g_top
      assign root_up[k] = in_root_index[IW-1:0];
    end else begin : g_mid
      assign root_up[k] = root_val[k-1];
    end
    if (k == RS - 1) begin : g_bot
      assign root_down[k] = '0;
    end else begin : g_up
      assign root_down[k] = root_val[k+1];
    end
    msbc_root_cell u_cell (
      .clk       (clk),
      .push      (push),
      .pop       (pop),
      .from_up   (root_up[k]),
      .from_down (root_down[k]),
      .val       (root_val[k])
    );
  end

  // Mark pass: a block is marked if any held root names it
  always_comb begin
    mark_cmb = '0;
    for (int b = 0; b < HB; b++) begin
      for (int k = 0; k < RS; k++) begin
        if ((DW'(k) < depth_r) && (root_val[k] == IW'(b))) begin
          mark_cmb[b] = 1'b1;
        end
      end
    end
  end

  assign out_free = !out_valid_r || !out_stall;
  assign in_stall = (state_r != msbc_pkg::ST_IDLE) || (out_valid_r && out_stall);
  assign in_acc   = in_valid && !in_stall;
  // root must be in range and currently allocated
  assign idx_ok   = (in_root_index < 8'(HB)) && live[in_root_index[IW-1:0]];

  always_comb begin
    state_nxt   = state_r;
    depth_nxt   = depth_r;
    launch_nxt  = '0;
    done_st_nxt = done_st_r;
    marks_nxt   = marks_r;
    push        = 1'b0;
    pop         = 1'b0;
    ld_out      = 1'b0;
    o_status    = msbc_pkg::STAT_OK;
    o_changed   = '0;
    o_popped    = '0;
    case (state_r)
      msbc_pkg::ST_IDLE: begin
        if (in_acc) begin
          case (msbc_pkg::msbc_kind_t'(in_kind))
            msbc_pkg::KIND_ALLOC: begin
              launch_nxt.vld     = 1'b1;
              launch_nxt.collect = 1'b0;
              launch_nxt.rem     = in_block_count;
              state_nxt          = msbc_pkg::ST_SWEEP;
            end
            msbc_pkg::KIND_COLLECT: begin
              launch_nxt.vld     = 1'b1;
              launch_nxt.collect = 1'b1;
              marks_nxt          = mark_cmb;
              state_nxt          = msbc_pkg::ST_SWEEP;
            end
            msbc_pkg::KIND_PUSH: begin
              ld_out = 1'b1;
              if (depth_r >= DW'(RS)) begin
                o_status = msbc_pkg::STAT_OVERFLOW;
              end else if (!idx_ok) begin
                o_status = msbc_pkg::STAT_INVALID;
              end else begin
                push      = 1'b1;
                depth_nxt = depth_r + DW'(1);
              end
            end
            msbc_pkg::KIND_POP: begin
              ld_out = 1'b1;
              if (depth_r == '0) begin
                o_status = msbc_pkg::STAT_UNDERFLOW;
              end else begin
                pop       = 1'b1;
                depth_nxt = depth_r - DW'(1);
                o_popped  = root_val[0];
              end
            end
            default: begin
              ld_out = 1'b0;
            end
          endcase
        end
      end
      msbc_pkg::ST_SWEEP: begin
        // leftover request count at the tail means the heap ran out
        if (tok[HB].vld) begin
          done_st_nxt = (!tok[HB].collect && (tok[HB].rem != '0)) ?
                        msbc_pkg::STAT_HEAP_FULL : msbc_pkg::STAT_OK;
          state_nxt   = msbc_pkg::ST_DONE;
        end
      end
      msbc_pkg::ST_DONE: begin
        if (out_free) begin
          ld_out    = 1'b1;
          o_status  = done_st_r;
          o_changed = chg;
          state_nxt = msbc_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = msbc_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (ld_out) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= msbc_pkg::ST_IDLE;
      depth_r     <= '0;
      launch_r    <= '0;
      done_st_r   <= msbc_pkg::STAT_OK;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      depth_r     <= depth_nxt;
      launch_r    <= launch_nxt;
      done_st_r   <= done_st_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    marks_r <= marks_nxt;
    if (ld_out) begin
      out_status_r  <= o_status;
      out_changed_r <= 16'(o_changed);
      out_popped_r  <= 4'(o_popped);
      out_live_r    <= 16'(live);
      out_held_r    <= 4'(depth_nxt);
    end
  end

  assign out_valid        = out_valid_r;
  assign out_status       = out_status_r;
  assign out_changed_mask = out_changed_r;
  assign out_popped_index = out_popped_r;
  assign out_live_mask    = out_live_r;
  assign out_roots_held   = out_held_r;

endmodule

// ===== design/msbc_heap_cell.sv =====
module msbc_heap_cell (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              clr,
  input  logic              mark,
  input  msbc_pkg::msbc_tok_t tok_in,
  output msbc_pkg::msbc_tok_t tok_out,
  output logic              alloc,
  output logic              changed
);

  msbc_pkg::msbc_tok_t tok_r, tok_nxt;
  logic alloc_r, alloc_nxt;
  logic chg_r, chg_nxt;

  always_comb begin
    tok_nxt   = tok_in;
    alloc_nxt = alloc_r;
    chg_nxt   = clr ? 1'b0 : chg_r;
    if (tok_in.vld) begin
      if (tok_in.collect) begin
        // unmarked live block gets freed
        if (alloc_r && !mark) begin
          alloc_nxt = 1'b0;
          chg_nxt   = 1'b1;
        end
      end else if (!alloc_r && (tok_in.rem != '0)) begin
        alloc_nxt   = 1'b1;
        chg_nxt     = 1'b1;
        tok_nxt.rem = tok_in.rem - msbc_pkg::CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tok_r   <= '0;
      alloc_r <= 1'b0;
      chg_r   <= 1'b0;
    end else begin
      tok_r   <= tok_nxt;
      alloc_r <= alloc_nxt;
      chg_r   <= chg_nxt;
    end
  end

  assign tok_out = tok_r;
  assign alloc   = alloc_r;
  assign changed = chg_r;

endmodule

// ===== design/msbc_root_cell.sv =====
module msbc_root_cell (
  input  logic                            clk,
  input  logic                            push,
  input  logic                            pop,
  input  logic [msbc_pkg::HEAP_IDX_W-1:0] from_up,
  input  logic [msbc_pkg::HEAP_IDX_W-1:0] from_down,
  output logic [msbc_pkg::HEAP_IDX_W-1:0] val
);

  logic [msbc_pkg::HEAP_IDX_W-1:0] val_r, val_nxt;

  // push shifts away from the top, pop shifts toward it
  always_comb begin
    val_nxt = val_r;
    if (push) begin
      val_nxt = from_up;
    end else if (pop) begin
      val_nxt = from_down;
    end
  end

  always_ff @(posedge clk) begin
    val_r <= val_nxt;
  end

  assign val = val_r;

endmodule

// ===== design/msbc_checker.sv =====
`include "mark_sweep_block_collector_defines.svh"

module msbc_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_stall,
  input logic [2:0]  out_status,
  input logic [15:0] out_changed_mask,
  input logic [3:0]  out_popped_index,
  input logic [15:0] out_live_mask,
  input logic [3:0]  out_roots_held
);

  `MSBC_IMPLY(a_held_range, out_valid, out_roots_held <= 4'(msbc_pkg::ROOT_SLOTS), "root count out of range")
  `MSBC_IMPLY(a_pop_clean, out_valid && (out_popped_index != 4'd0), (out_status == msbc_pkg::STAT_OK) && (out_changed_mask == 16'd0), "pop word carries a change")
  `MSBC_IMPLY(a_full_heap, out_valid && (out_status == msbc_pkg::STAT_HEAP_FULL), out_live_mask == 16'({msbc_pkg::HEAP_BLOCKS{1'b1}}), "heap full with free blocks left")
  `MSBC_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_live_mask) && $stable(out_status), "stalled word changed")

endmodule

bind mark_sweep_block_collector msbc_checker u_msbc_checker (.*);

// ===== verif/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;

  // One result word as the block returns it, fields in port order.
  typedef struct packed {
    msbc_pkg::msbc_status_t status;
    logic [15:0]            changed;
    logic [3:0]             popped;
    logic [15:0]            live;
    logic [3:0]             roots;
  } collector_word_t;

  // Directed stimulus row. When pinned is set, want holds a hand-typed
  // result; otherwise the predictor supplies the expectation.
  typedef struct {
    msbc_pkg::msbc_kind_t kind;
    logic [4:0]           count;
    logic [7:0]           idx;
    bit                   pinned;
    collector_word_t      want;
  } script_row_t;

  // Generous bound: roughly 800 words, plus the long receiver hold and the
  // drains between phases.
  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int          RANDOM_PER_PHASE = 270;
  localparam int          HOLD_CYCLES = 150;
  localparam int          SETTLE_CYCLES = 40;   // outlasts a heap sweep and its result

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [1:0]  in_kind = msbc_pkg::KIND_ALLOC;
  logic [4:0]  in_block_count = '0;
  logic [7:0]  in_root_index = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [2:0]  out_status;
  logic [15:0] out_changed_mask;
  logic [3:0]  out_popped_index;
  logic [15:0] out_live_mask;
  logic [3:0]  out_roots_held;

  // Predictor state: allocation bitmap and root stack.
  logic [15:0] heap_live;
  logic [3:0]  root_slot [msbc_pkg::ROOT_SLOTS];
  int          root_count;

  collector_word_t expected_words [$];
  collector_word_t oldest;
  int          mismatch_count = 0;
  int unsigned cycle_count = 0;

  // Idle rates in percent, changed per phase by the driver.
  int  send_idle_pct = 37;
  int  recv_stall_pct = 61;
  bit  hold_go = 1'b0;
  logic hold_off = 1'b0;

  mark_sweep_block_collector dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_kind          (in_kind),
    .in_block_count   (in_block_count),
    .in_root_index    (in_root_index),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_status       (out_status),
    .out_changed_mask (out_changed_mask),
    .out_popped_index (out_popped_index),
    .out_live_mask    (out_live_mask),
    .out_roots_held   (out_roots_held)
  );

  always #6 clk = ~clk;

  // Predict one accepted word and advance the shadow heap and root stack.
  function automatic collector_word_t apply_word(msbc_pkg::msbc_kind_t k, logic [4:0] cnt,
                                                 logic [7:0] idx);
    collector_word_t w;
    logic [15:0]     marks;
    int              got;
    w = '0;
    w.status = msbc_pkg::STAT_OK;
    marks = '0;
    got = 0;
    case (k)
      msbc_pkg::KIND_ALLOC: begin
        // lowest-numbered free blocks first; partial claims stick
        for (int b = 0; b < msbc_pkg::HEAP_BLOCKS; b++) begin
          if (got < int'(cnt) && !heap_live[b]) begin
            heap_live[b] = 1'b1;
            w.changed[b] = 1'b1;
            got++;
          end
        end
        if (got < int'(cnt)) w.status = msbc_pkg::STAT_HEAP_FULL;
      end
      msbc_pkg::KIND_PUSH: begin
        // overflow is checked ahead of the reference
        if (root_count >= msbc_pkg::ROOT_SLOTS) begin
          w.status = msbc_pkg::STAT_OVERFLOW;
        end else if (int'(idx) >= msbc_pkg::HEAP_BLOCKS || !heap_live[idx[3:0]]) begin
          w.status = msbc_pkg::STAT_INVALID;
        end else begin
          root_slot[root_count] = idx[3:0];
          root_count++;
        end
      end
      msbc_pkg::KIND_POP: begin
        if (root_count == 0) begin
          w.status = msbc_pkg::STAT_UNDERFLOW;
        end else begin
          root_count--;
          w.popped = root_slot[root_count];
        end
      end
      default: begin
        for (int i = 0; i < root_count; i++) marks[root_slot[i]] = 1'b1;
        w.changed = heap_live & ~marks;
        heap_live = heap_live & marks;
      end
    endcase
    w.live = heap_live;
    w.roots = 4'(root_count);
    return w;
  endfunction

  function automatic collector_word_t pin(msbc_pkg::msbc_status_t s, logic [15:0] chg,
                                          logic [3:0] pop, logic [15:0] live,
                                          logic [3:0] roots);
    collector_word_t w;
    w.status = s;
    w.changed = chg;
    w.popped = pop;
    w.live = live;
    w.roots = roots;
    return w;
  endfunction

  // One line per mismatch; every one is counted.
  task automatic flag_mismatch(string what, logic [15:0] got, logic [15:0] want);
    $display("%0t: mismatch on %s: got %h, expected %h", $realtime, what, got, want);
    mismatch_count++;
  endtask

  // Offer one word, holding it until taken, then record what it should produce.
  // Valid stays high into the next call unless the sender chooses to idle.
  task automatic send_word(msbc_pkg::msbc_kind_t k, logic [4:0] cnt, logic [7:0] idx,
                           bit pinned, collector_word_t want);
    collector_word_t predicted;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_kind <= k;
    in_block_count <= cnt;
    in_root_index <= idx;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predicted = apply_word(k, cnt, idx);
    expected_words.push_back(pinned ? want : predicted);
  endtask

  // Sender stops offering until every outstanding result word is back.
  task automatic drain_results();
    in_valid <= 1'b0;
    while (expected_words.size() != 0) @(posedge clk);
  endtask

  // Random traffic: pushes mostly name live blocks so the stack fills and
  // collects keep something alive; the rest probes bad references.
  task automatic send_random(int n);
    msbc_pkg::msbc_kind_t k;
    logic [4:0] cnt;
    logic [7:0] idx;
    int         roll;
    int         pick;
    for (int i = 0; i < n; i++) begin
      roll = $urandom_range(99);
      pick = $urandom_range(99);
      cnt = 5'($urandom_range(31));
      idx = 8'($urandom_range(255));
      if (roll < 30) begin
        k = msbc_pkg::KIND_ALLOC;
        // mostly small requests, now and then past the heap size
        if (pick < 80) cnt = 5'($urandom_range(6));
        else if (pick < 92) cnt = 5'($urandom_range(16, 7));
        else cnt = 5'($urandom_range(31, 17));
      end else if (roll < 65) begin
        k = msbc_pkg::KIND_PUSH;
        if (pick < 60 && heap_live != '0) begin
          idx = 8'($urandom_range(15));
          while (!heap_live[idx[3:0]]) idx = {4'h0, idx[3:0] + 4'd1};
        end else if (pick < 85) begin
          idx = 8'($urandom_range(15));
        end
      end else if (roll < 87) begin
        k = msbc_pkg::KIND_POP;
      end else begin
        k = msbc_pkg::KIND_COLLECT;
      end
      send_word(k, cnt, idx, 1'b0, '0);
    end
  endtask

  // Receiver: random stall plus the long hold-off.
  always @(posedge clk) begin
    out_stall <= hold_off || ($urandom_range(99) < recv_stall_pct);
  end

  // Long receiver hold, timed here so the sender keeps pushing meanwhile;
  // the block has to back up and raise in_stall.
  initial begin
    wait (hold_go);
    @(posedge clk);
    hold_off <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    hold_off <= 1'b0;
  end

  // Result checker: every taken word is matched against the oldest expectation.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (expected_words.size() == 0) begin
        flag_mismatch("unexpected word", out_live_mask, 16'h0);
      end else begin
        oldest = expected_words.pop_front();
        if (out_status != oldest.status)
          flag_mismatch("status", 16'(out_status), 16'(oldest.status));
        if (out_changed_mask != oldest.changed)
          flag_mismatch("changed_mask", out_changed_mask, oldest.changed);
        if (out_popped_index != oldest.popped)
          flag_mismatch("popped_index", 16'(out_popped_index), 16'(oldest.popped));
        if (out_live_mask != oldest.live)
          flag_mismatch("live_mask", out_live_mask, oldest.live);
        if (out_roots_held != oldest.roots)
          flag_mismatch("roots_held", 16'(out_roots_held), 16'(oldest.roots));
      end
    end
  end

  // Watchdog.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  initial begin : stimulus
    script_row_t script [$];

    heap_live = '0;
    root_count = 0;
    foreach (root_slot[i]) root_slot[i] = '0;

    // Directed part. Early rows run from the reset state, so their results
    // are obvious; later ones lean on the predictor.
    // empty stack, empty heap
    script.push_back('{msbc_pkg::KIND_POP, 5'd0, 8'd0, 1'b1,
                       pin(msbc_pkg::STAT_UNDERFLOW, 16'h0, 4'd0, 16'h0, 4'd0)});
    script.push_back('{msbc_pkg::KIND_PUSH, 5'd0, 8'd0, 1'b1,
                       pin(msbc_pkg::STAT_INVALID, 16'h0, 4'd0, 16'h0, 4'd0)});
    script.push_back('{msbc_pkg::KIND_COLLECT, 5'd31, 8'd255, 1'b1,
                       pin(msbc_pkg::STAT_OK, 16'h0, 4'd0, 16'h0, 4'd0)});
    // zero request, then the whole heap, then an oversize request on a full heap
    script.push_back('{msbc_pkg::KIND_ALLOC, 5'd0, 8'd255, 1'b1,
                       pin(msbc_pkg::STAT_OK, 16'h0, 4'd0, 16'h0, 4'd0)});
    script.push_back('{msbc_pkg::KIND_ALLOC, 5'd16, 8'd0, 1'b1,
                       pin(msbc_pkg::STAT_OK, 16'hffff, 4'd0, 16'hffff, 4'd0)});
    script.push_back('{msbc_pkg::KIND_ALLOC, 5'd31, 8'd0, 1'b1,
                       pin(msbc_pkg::STAT_HEAP_FULL, 16'h0, 4'd0, 16'hffff, 4'd0)});
    // out-of-range references, then the highest valid one
    script.push_back('{msbc_pkg::KIND_PUSH, 5'd0, 8'd255, 1'b1,
                       pin(msbc_pkg::STAT_INVALID, 16'h0, 4'd0, 16'hffff, 4'd0)});
    script.push_back('{msbc_pkg::KIND_PUSH, 5'd0, 8'd16, 1'b1,
                       pin(msbc_pkg::STAT_INVALID, 16'h0, 4'd0, 16'hffff, 4'd0)});
    script.push_back('{msbc_pkg::KIND_PUSH, 5'd31, 8'd15, 1'b1,
                       pin(msbc_pkg::STAT_OK, 16'h0, 4'd0, 16'hffff, 4'd1)});
    // fill the stack, including a duplicate root
    script.push_back('{msbc_pkg::KIND_PUSH, 5'd0, 8'd0, 1'b0, '0});
    script.push_back('{msbc_pkg::KIND_PUSH, 5'd0, 8'd15, 1'b0, '0});
    script.push_back('{msbc_pkg::KIND_PUSH, 5'd0, 8'd5, 1'b0, '0});
    script.push_back('{msbc_pkg::KIND_PUSH, 5'd0, 8'd6, 1'b0, '0});
    script.push_back('{msbc_pkg::KIND_PUSH, 5'd0, 8'd7, 1'b0, '0});
    script.push_back('{msbc_pkg::KIND_PUSH, 5'd0, 8'd8, 1'b0, '0});
    script.push_back('{msbc_pkg::KIND_PUSH, 5'd0, 8'd9, 1'b0, '0});
    script.push_back('{msbc_pkg::KIND_PUSH, 5'd0, 8'd3, 1'b1,
                       pin(msbc_pkg::STAT_OVERFLOW, 16'h0, 4'd0, 16'hffff, 4'd8)});
    // full stack wins over a bad reference
    script.push_back('{msbc_pkg::KIND_PUSH, 5'd0, 8'd200, 1'b0, '0});
    // sweep everything not rooted, then unwind a little
    script.push_back('{msbc_pkg::KIND_COLLECT, 5'd0, 8'd0, 1'b0, '0});
    script.push_back('{msbc_pkg::KIND_POP, 5'd31, 8'd255, 1'b0, '0});
    script.push_back('{msbc_pkg::KIND_POP, 5'd0, 8'd0, 1'b0, '0});
    // in range but freed by the sweep
    script.push_back('{msbc_pkg::KIND_PUSH, 5'd0, 8'd1, 1'b0, '0});
    script.push_back('{msbc_pkg::KIND_COLLECT, 5'd0, 8'd0, 1'b0, '0});
    // partial refill from the bottom, then a short heap
    script.push_back('{msbc_pkg::KIND_ALLOC, 5'd3, 8'd255, 1'b0, '0});
    script.push_back('{msbc_pkg::KIND_ALLOC, 5'd31, 8'd0, 1'b0, '0});

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Phase one: sender idles often, receiver stalls more often.
    foreach (script[i])
      send_word(script[i].kind, script[i].count, script[i].idx, script[i].pinned,
                script[i].want);
    send_random(RANDOM_PER_PHASE);
    drain_results();

    // Phase two: rates swapped.
    send_idle_pct = 61;
    recv_stall_pct = 37;
    send_random(RANDOM_PER_PHASE);
    drain_results();

    // Phase three: back-to-back, opening with a long receiver hold.
    send_idle_pct = 0;
    recv_stall_pct = 0;
    hold_go = 1'b1;
    send_random(RANDOM_PER_PHASE);
    drain_results();

    // Catch any stray words trailing the last result.
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && expected_words.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+design
design/msbc_pkg.sv
design/msbc_heap_cell.sv
design/msbc_root_cell.sv
design/mark_sweep_block_collector.sv
design/msbc_checker.sv
verif/tb_top.sv
